/* src/euler_point_rotation_unit_defines.svh */
// assertion macros for the euler point rotation unit
`ifndef EULER_POINT_ROTATION_UNIT_DEFINES_SVH
`define EULER_POINT_ROTATION_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define EPR_ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("epr check failed");
`define EPR_ASSERT_NORST(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("epr check failed");
`else
`define EPR_ASSERT_IMPL(label, clk, rst_n, prop)
`define EPR_ASSERT_NORST(label, clk, prop)
`endif
`endif

/* src/epr_pkg.sv */
// ---------------------------------------------------------------------------
// epr_pkg
// types, cordic constants and arctangent table for the rotation unit
// ---------------------------------------------------------------------------
`default_nettype none
package epr_pkg;
	localparam int CW = 32;
	localparam int AW = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam logic [31:0] CORDIC_START = 32'h26DD3B6A;
	localparam int TRIG_ONE = 268435456;

	typedef struct packed {
		logic signed [CW-1:0] point_x;
		logic signed [CW-1:0] point_y;
		logic signed [CW-1:0] point_z;
		logic signed [AW-1:0] angle_about_x;
		logic signed [AW-1:0] angle_about_y;
		logic signed [AW-1:0] angle_about_z;
	} in_word_t;

	typedef struct packed {
		logic signed [CW-1:0] rotated_x;
		logic signed [CW-1:0] rotated_y;
		logic signed [CW-1:0] rotated_z;
	} out_word_t;

	function automatic logic [31:0] atan_phase(input int i);
		logic [31:0] r;
		begin
			case (i)
				0: r = 32'h20000000;  1: r = 32'h12E4051E;
				2: r = 32'h09FB385B;  3: r = 32'h051111D4;
				4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
				6: r = 32'h00A2F61E;  7: r = 32'h00517C55;
				8: r = 32'h0028BE53;  9: r = 32'h00145F2F;
				10: r = 32'h000A2F98; 11: r = 32'h000517CC;
				12: r = 32'h00028BE6; 13: r = 32'h000145F3;
				14: r = 32'h0000A2FA; 15: r = 32'h0000517D;
				16: r = 32'h000028BE; 17: r = 32'h0000145F;
				18: r = 32'h00000A30; 19: r = 32'h00000518;
				20: r = 32'h0000028C; 21: r = 32'h00000146;
				22: r = 32'h000000A3; 23: r = 32'h00000051;
				default: r = 32'h0;
			endcase
			return r;
		end
	endfunction
endpackage
`default_nettype wire

/* src/epr_cordic_cell.sv */
// ---------------------------------------------------------------------------
// epr_cordic_cell
// one registered cordic micro-rotation; carries a side payload along
// ---------------------------------------------------------------------------
`default_nettype none
module epr_cordic_cell #(
	parameter int STEP = 0,
	parameter int PW = 1
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic signed [33:0] x_in,
	input  wire logic signed [33:0] y_in,
	input  wire logic signed [33:0] z_in,
	input  wire logic [PW-1:0]     pay_in,
	output logic signed [33:0]     x_out,
	output logic signed [33:0]     y_out,
	output logic signed [33:0]     z_out,
	output logic [PW-1:0]          pay_out
);
	import epr_pkg::*;
	localparam logic signed [33:0] ATAN = $signed({2'b00, atan_phase(STEP)});
	logic signed [33:0] xs, ys;
	assign xs = x_in >>> STEP;
	assign ys = y_in >>> STEP;
	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_in[33]) begin
				x_out <= x_in - ys;
				y_out <= y_in + xs;
				z_out <= z_in - ATAN;
			end else begin
				x_out <= x_in + ys;
				y_out <= y_in - xs;
				z_out <= z_in + ATAN;
			end
			pay_out <= pay_in;
		end
	end
endmodule
`default_nettype wire

/* src/epr_rot_stage.sv */
// ---------------------------------------------------------------------------
// epr_rot_stage
// one axis rotation: cordic cell chain for sin/cos, then a product pipeline
// ---------------------------------------------------------------------------
`default_nettype none
module epr_rot_stage #(
	parameter int VW = 50,
	parameter int AWID = 16,
	parameter int ITER = 16,
	parameter int PW = 1
) (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [VW-1:0] u_in,
	input  wire logic signed [VW-1:0] v_in,
	input  wire logic [AWID-1:0]    ang_in,
	input  wire logic [PW-1:0]      pay_in,
	output logic signed [VW-1:0]    u_out,
	output logic signed [VW-1:0]    v_out,
	output logic [PW-1:0]           pay_out
);
	import epr_pkg::*;
	localparam int CPW = 2*VW + 2 + PW;
	logic signed [33:0] cx [0:ITER];
	logic signed [33:0] cy [0:ITER];
	logic signed [33:0] cz [0:ITER];
	logic [CPW-1:0]     cp [0:ITER];
	logic [31:0] phase, phs;
	logic neg0, skip0;

	assign phase = {ang_in, {(32-AWID){1'b0}}};
	assign neg0 = phase[31] ^ phase[30];
	assign phs = neg0 ? phase + 32'h80000000 : phase;
	assign skip0 = (ang_in == '0);
	assign cx[0] = $signed({2'b00, CORDIC_START});
	assign cy[0] = '0;
	assign cz[0] = {{2{phs[31]}}, phs};
	assign cp[0] = {u_in, v_in, neg0, skip0, pay_in};

	for (genvar i = 0; i < ITER; i++) begin : g_cell
		epr_cordic_cell #(.STEP(i), .PW(CPW)) u_cell (
			.clk(clk), .en(en),
			.x_in(cx[i]), .y_in(cy[i]), .z_in(cz[i]), .pay_in(cp[i]),
			.x_out(cx[i+1]), .y_out(cy[i+1]), .z_out(cz[i+1]), .pay_out(cp[i+1])
		);
	end

	// round q30 to q28, clamp, fix sign
	logic signed [33:0] cr, sr;
	logic signed [29:0] cq, sq;
	logic neg, skip;
	logic signed [VW-1:0] u, v;
	assign cr = (cx[ITER] + 34'sd2) >>> 2;
	assign sr = (cy[ITER] + 34'sd2) >>> 2;
	assign {u, v, neg, skip} = cp[ITER][CPW-1:PW];

	function automatic logic signed [29:0] clampt(input logic signed [33:0] a, input logic n);
		logic signed [29:0] r;
		begin
			if (a > 34'sd268435456) r = 30'sd268435456;
			else if (a < -34'sd268435456) r = -30'sd268435456;
			else r = a[29:0];
			return n ? -r : r;
		end
	endfunction
	assign cq = clampt(cr, neg);
	assign sq = clampt(sr, neg);

	// s1: trig registered
	logic signed [29:0] c_s1, s_s1;
	logic signed [VW-1:0] u_s1, v_s1;
	logic skip_s1;
	logic [PW-1:0] pay_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			c_s1 <= cq; s_s1 <= sq; u_s1 <= u; v_s1 <= v;
			skip_s1 <= skip; pay_s1 <= cp[ITER][PW-1:0];
		end
	end

	// s2: partial products, hi part (arith >>16) and lo 16 bits
	localparam int HW = VW - 16;
	localparam int PH = HW + 30;
	logic signed [PH-1:0] uc_h_s2, vs_h_s2, us_h_s2, vc_h_s2;
	logic signed [46:0] uc_l_s2, vs_l_s2, us_l_s2, vc_l_s2;
	logic signed [VW-1:0] u_s2, v_s2;
	logic skip_s2;
	logic [PW-1:0] pay_s2;
	logic signed [HW-1:0] uh, vh;
	logic signed [16:0] ul, vl;
	assign uh = u_s1[VW-1:16];
	assign vh = v_s1[VW-1:16];
	assign ul = $signed({1'b0, u_s1[15:0]});
	assign vl = $signed({1'b0, v_s1[15:0]});
	always_ff @(posedge clk) begin
		if (en) begin
			uc_h_s2 <= PH'(uh * c_s1); vs_h_s2 <= PH'(vh * s_s1);
			us_h_s2 <= PH'(uh * s_s1); vc_h_s2 <= PH'(vh * c_s1);
			uc_l_s2 <= 47'(ul * c_s1); vs_l_s2 <= 47'(vl * s_s1);
			us_l_s2 <= 47'(ul * s_s1); vc_l_s2 <= 47'(vl * c_s1);
			u_s2 <= u_s1; v_s2 <= v_s1; skip_s2 <= skip_s1; pay_s2 <= pay_s1;
		end
	end

	function automatic logic signed [VW-1:0] mq(input logic signed [PH-1:0] p,
		input logic signed [46:0] q);
		logic signed [PH-1:0] ph;
		logic signed [48:0] t;
		begin
			ph = p >>> 12;
			t = $signed({1'b0, p[11:0], 16'h0}) + 49'(q) + 49'sd134217728;
			return VW'(ph) + VW'(t >>> 28);
		end
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			if (skip_s2) begin
				u_out <= u_s2; v_out <= v_s2;
			end else begin
				u_out <= mq(uc_h_s2, uc_l_s2) - mq(vs_h_s2, vs_l_s2);
				v_out <= mq(us_h_s2, us_l_s2) + mq(vc_h_s2, vc_l_s2);
			end
			pay_out <= pay_s2;
		end
	end
endmodule
`default_nettype wire

/* src/euler_point_rotation_unit.sv */
// ---------------------------------------------------------------------------
// euler_point_rotation_unit
// rotates a q16.16 point about y, then z, then x; pipelined cordic cell chains
// ---------------------------------------------------------------------------
// channel | direction | handshake          | word
// in      | into      | in_valid/in_ready  | point and three binary angles
// out     | out of    | out_valid/out_ready| saturated rotated point
//
// one word per cycle sustained while out_ready is high; the pipe is three cordic
// chains of one cell per iteration plus three product stages each, then the
// output register; the whole pipe advances together and holds when the output
// register is full and not taken; reset clears only the valid bits, no clearing pass
// ---------------------------------------------------------------------------
`default_nettype none
`include "euler_point_rotation_unit_defines.svh"
module euler_point_rotation_unit #(
	parameter int TRIG_ITERATIONS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire epr_pkg::in_word_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output epr_pkg::out_word_t      out_data
);
	import epr_pkg::*;
	// intermediate width with headroom for three rotations
	localparam int VW = CW + 18;
	localparam int LAT = 3*(TRIG_ITERATIONS+3);

	logic en;
	logic [LAT-1:0] vld_q;
	// pipe moves whenever the output slot is free or being drained
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[LAT-2:0], in_valid};
	end

	logic signed [VW-1:0] x0, y0, z0, z1, x1, x2, y2, y3, z3;
	logic [2*AW-1:0] ang1;
	logic [AW-1:0] ang2;
	logic [VW-1:0] ypass;
	logic [2*AW+VW-1:0] p1;
	assign x0 = VW'(in_data.point_x);
	assign y0 = VW'(in_data.point_y);
	assign z0 = VW'(in_data.point_z);

	// about y: (z, x)
	epr_rot_stage #(.VW(VW), .AWID(AW), .ITER(TRIG_ITERATIONS), .PW(2*AW+VW)) u_rot_y (
		.clk(clk), .en(en), .u_in(z0), .v_in(x0), .ang_in(in_data.angle_about_y),
		.pay_in({in_data.angle_about_z, in_data.angle_about_x, y0}),
		.u_out(z1), .v_out(x1), .pay_out(p1)
	);
	assign ang1 = p1[2*AW+VW-1:VW];
	assign ypass = p1[VW-1:0];

	// about z: (x, y)
	logic [AW+VW-1:0] p2;
	epr_rot_stage #(.VW(VW), .AWID(AW), .ITER(TRIG_ITERATIONS), .PW(AW+VW)) u_rot_z (
		.clk(clk), .en(en), .u_in(x1), .v_in($signed(ypass)), .ang_in(ang1[2*AW-1:AW]),
		.pay_in({ang1[AW-1:0], z1}), .u_out(x2), .v_out(y2), .pay_out(p2)
	);
	assign ang2 = p2[AW+VW-1:VW];

	// about x: (y, z)
	logic [VW-1:0] p3;
	epr_rot_stage #(.VW(VW), .AWID(AW), .ITER(TRIG_ITERATIONS), .PW(VW)) u_rot_x (
		.clk(clk), .en(en), .u_in(y2), .v_in($signed(p2[VW-1:0])), .ang_in(ang2),
		.pay_in(x2), .u_out(y3), .v_out(z3), .pay_out(p3)
	);

	// saturate to coordinate range
	function automatic logic signed [CW-1:0] sat(input logic signed [VW-1:0] a);
		logic signed [VW-1:0] hi, lo;
		begin
			hi = VW'({1'b0, {(CW-1){1'b1}}});
			lo = -hi - VW'(1);
			if (a > hi) return hi[CW-1:0];
			else if (a < lo) return lo[CW-1:0];
			else return a[CW-1:0];
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= vld_q[LAT-1];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			out_data.rotated_x <= sat($signed(p3));
			out_data.rotated_y <= sat(y3);
			out_data.rotated_z <= sat(z3);
		end
	end

	// stall holds the output word
	`EPR_ASSERT_IMPL(a_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_data))
	// ready is exactly the free-slot condition
	`EPR_ASSERT_IMPL(a_rdy, clk, arst_n, in_ready == (!out_valid || out_ready))
	// a word entering reaches the pipe valid chain
	`EPR_ASSERT_IMPL(a_enter, clk, arst_n, in_valid && in_ready |=> vld_q[0])
endmodule
`default_nettype wire
